// ===== hw/rtl/acg_pkg.sv =====
// ----------------------------------------------------------------------------
// acg_pkg: shared types and constants of the anchored color gradient
// Anchor table size, request and status codes, and the beat and
// inter-module struct types.
// ----------------------------------------------------------------------------
package acg_pkg;

	localparam int MAX_ANCHORS = 16;
	localparam int IDX_W       = $clog2(MAX_ANCHORS);
	localparam int CNT_W       = $clog2(MAX_ANCHORS + 1);

	// request kinds
	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// result status codes
	localparam logic [1:0] ST_COLOR  = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_STORED = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic              req_type;
		logic signed [15:0] position;
		logic [7:0]        red_in;
		logic [7:0]        green_in;
		logic [7:0]        blue_in;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] key;
		logic [23:0]        color;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           entry;
	} tbl_wr_t;

	typedef struct packed {
		logic        start;
		logic [23:0] c0;
		logic [23:0] c1;
		logic [15:0] num;
		logic [15:0] den;
	} lerp_cmd_t;

	typedef struct packed {
		logic        done;
		logic [23:0] rgb;
	} lerp_rsp_t;

endpackage

// ===== hw/rtl/acg_table.sv =====
// ----------------------------------------------------------------------------
// acg_table: anchor storage
// One write port and one registered read port over the sorted anchor table.
// ----------------------------------------------------------------------------
module acg_table (
	input  logic                      clk,
	input  acg_pkg::tbl_wr_t          wr,
	input  logic [acg_pkg::IDX_W-1:0] rd_addr,
	output acg_pkg::entry_t           rd
);

	acg_pkg::entry_t mem_q [acg_pkg::MAX_ANCHORS];
	acg_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.entry;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd = rd_q;

endmodule

// ===== hw/rtl/acg_lerp.sv =====
// ----------------------------------------------------------------------------
// acg_lerp: serial channel interpolator
// One multiplier and one restoring divide step, reused for red, green, blue.
// ----------------------------------------------------------------------------
module acg_lerp (
	input  logic               clk,
	input  logic               arst_n,
	input  acg_pkg::lerp_cmd_t cmd,
	output acg_pkg::lerp_rsp_t rsp
);

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_MUL  = 2'd1;
	localparam logic [1:0] L_DIV  = 2'd2;
	localparam logic [1:0] L_FIN  = 2'd3;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	logic [1:0]  state_q;
	logic [1:0]  ch_q;
	logic [2:0]  cnt_q;
	logic        done_q;
	logic [23:0] c0_q, c1_q, rgb_q;
	logic [15:0] num_q, den_q;
	logic [23:0] rem_q, dsh_q;
	logic [7:0]  base_q, quo_q;
	logic        neg_q;

	logic [7:0]  base, nxt, mag;
	logic [8:0]  diff;
	logic        ge;
	logic [9:0]  sum;
	logic [7:0]  clamped;

	function automatic logic [7:0] chan(input logic [23:0] color, input logic [1:0] ch);
		logic [7:0] v;
		case (ch)
			CH_RED:   v = color[23:16];
			CH_GREEN: v = color[15:8];
			default:  v = color[7:0];
		endcase
		return v;
	endfunction

	always_comb begin
		base = chan(c0_q, ch_q);
		nxt  = chan(c1_q, ch_q);
		diff = {1'b0, nxt} - {1'b0, base};
		mag  = diff[8] ? 8'(-diff) : diff[7:0];
		ge   = (rem_q >= dsh_q);
		sum  = neg_q ? ({2'b00, base_q} - {2'b00, quo_q}) : ({2'b00, base_q} + {2'b00, quo_q});
		if (sum[9]) begin
			clamped = 8'd0;
		end else if (sum[8]) begin
			clamped = 8'd255;
		end else begin
			clamped = sum[7:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			ch_q    <= CH_RED;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (cmd.start) begin
						ch_q    <= CH_RED;
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					cnt_q   <= 3'd7;
					state_q <= L_DIV;
				end
				L_DIV: begin
					cnt_q <= cnt_q - 3'd1;
					if (cnt_q == 3'd0) begin
						state_q <= L_FIN;
					end
				end
				L_FIN: begin
					if (ch_q == CH_BLUE) begin
						done_q  <= 1'b1;
						state_q <= L_IDLE;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= L_MUL;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (cmd.start) begin
					c0_q  <= cmd.c0;
					c1_q  <= cmd.c1;
					num_q <= cmd.num;
					den_q <= cmd.den;
				end
			end
			L_MUL: begin
				base_q <= base;
				neg_q  <= diff[8];
				rem_q  <= 24'(mag) * 24'(num_q);
				dsh_q  <= {1'b0, den_q, 7'b0};
				quo_q  <= '0;
			end
			L_DIV: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[6:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			default: begin
				case (ch_q)
					CH_RED:   rgb_q[23:16] <= clamped;
					CH_GREEN: rgb_q[15:8]  <= clamped;
					default:  rgb_q[7:0]   <= clamped;
				endcase
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.rgb  = rgb_q;

endmodule

// ===== hw/rtl/anchored_color_gradient.sv =====
// ----------------------------------------------------------------------------
// anchored_color_gradient: piecewise linear color ramp over sorted anchors
// Stores keyed RGB anchors and answers color queries by interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one request beat: a
//   store of an anchor (key plus color) or a color query at a position.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one beat per
//   request: status plus the red, green and blue result (zero unless the
//   status says the color is valid).
//   One request is worked at a time; req_stall stays high from acceptance
//   until the result has been moved into the output register; the sequencer
//   is then idle again, and the next request can be taken.
//   Steps from the accepting edge; the scan reads one anchor per cycle:
//     store: scan until the key is found or passed (an equal key is
//            overwritten in place), else full check, moving the anchors
//            above the slot up one place, top first, then write and hand-off.
//     query: scan plus hand-off; a hit segment adds a pass through the
//            shared interpolator (per channel: one multiply, eight divide
//            steps, one clamp).
//   The output register holds a finished beat while rsp_stall is high; the
//   sequencer then waits in its final state and holds the next result.
//   Reset empties the table (anchor count zero); stored entries need no
//   clearing, since only the first count entries are ever used.
// ----------------------------------------------------------------------------
module anchored_color_gradient (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  acg_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output acg_pkg::rsp_t rsp
);

	localparam int IW = acg_pkg::IDX_W;
	localparam int CW = acg_pkg::CNT_W;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_INS   = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;
	localparam logic [2:0] S_LERP  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	// control state
	logic [2:0]    state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [IW-1:0] sh_q, sh_d;
	logic [CW-1:0] at_q, at_d;
	logic [CW-1:0] count_q, count_d;
	logic          rsp_valid_q;

	// request payload and working values
	logic               type_q;
	logic signed [15:0] pos_q;
	logic [23:0]        color_q;
	logic signed [15:0] prev_key_q, prev_key_d;
	logic [23:0]        prev_color_q, prev_color_d;
	acg_pkg::rsp_t      res_q, res_d;
	acg_pkg::rsp_t      rsp_q;

	// table and interpolator ports
	acg_pkg::tbl_wr_t   wr;
	logic [IW-1:0]      rd_addr;
	acg_pkg::entry_t    rd;
	acg_pkg::lerp_cmd_t lcmd;
	acg_pkg::lerp_rsp_t lrsp;

	logic signed [15:0] rd_key;
	logic [23:0]        rd_color;
	logic [CW-1:0]      last_idx;
	logic               is_last;
	logic               load_item;
	logic               out_free;

	acg_table u_table (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd      (rd)
	);

	acg_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lcmd),
		.rsp    (lrsp)
	);

	assign rd_key   = rd.key;
	assign rd_color = rd.color;
	assign last_idx = count_q - CW'(1);
	assign is_last  = (CW'(idx_q) == last_idx);
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Take a new request only when the sequencer is idle.
	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		sh_d         = sh_q;
		at_d         = at_q;
		count_d      = count_q;
		prev_key_d   = prev_key_q;
		prev_color_d = prev_color_q;
		res_d        = res_q;
		rd_addr      = '0;
		wr           = '0;
		lcmd         = '0;
		load_item    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					load_item = 1'b1;
					idx_d     = '0;
					res_d     = '0;
					if (count_q != '0) begin
						// fetch the first anchor and start the scan
						state_d = S_SCAN;
					end else if (req.req_type == acg_pkg::REQ_STORE) begin
						at_d    = '0;
						state_d = S_INS;
					end else begin
						res_d.status = acg_pkg::ST_RANGE;
						state_d      = S_DONE;
					end
				end
			end

			S_SCAN: begin
				if (type_q == acg_pkg::REQ_STORE) begin
					if (rd_key == pos_q) begin
						// equal key: overwrite the color in place
						wr.en          = 1'b1;
						wr.addr        = idx_q;
						wr.entry.key   = rd_key;
						wr.entry.color = color_q;
						res_d.status   = acg_pkg::ST_STORED;
						state_d        = S_DONE;
					end else if (rd_key > pos_q) begin
						at_d    = CW'(idx_q);
						state_d = S_INS;
					end else if (is_last) begin
						at_d    = count_q;
						state_d = S_INS;
					end else begin
						idx_d   = idx_q + IW'(1);
						rd_addr = idx_q + IW'(1);
					end
				end else begin
					if (idx_q == '0 && pos_q < rd_key) begin
						res_d.status = acg_pkg::ST_RANGE;
						state_d      = S_DONE;
					end else if (idx_q == '0 && pos_q == rd_key) begin
						// query right on the first anchor: its own color
						res_d.status    = acg_pkg::ST_COLOR;
						res_d.red_out   = rd_color[23:16];
						res_d.green_out = rd_color[15:8];
						res_d.blue_out  = rd_color[7:0];
						state_d         = S_DONE;
					end else if (idx_q != '0 && rd_key >= pos_q) begin
						// first segment that encloses the position
						lcmd.start = 1'b1;
						lcmd.c0    = prev_color_q;
						lcmd.c1    = rd_color;
						lcmd.num   = 16'(pos_q - prev_key_q);
						lcmd.den   = 16'(rd_key - prev_key_q);
						state_d    = S_LERP;
					end else if (is_last) begin
						res_d.status = acg_pkg::ST_RANGE;
						state_d      = S_DONE;
					end else begin
						prev_key_d   = rd_key;
						prev_color_d = rd_color;
						idx_d        = idx_q + IW'(1);
						rd_addr      = idx_q + IW'(1);
					end
				end
			end

			S_INS: begin
				if (count_q == CW'(acg_pkg::MAX_ANCHORS)) begin
					res_d.status = acg_pkg::ST_FULL;
					state_d      = S_DONE;
				end else if (at_q == count_q) begin
					state_d = S_PUT;
				end else begin
					// open a slot: move the tail up one place, top first
					rd_addr = IW'(last_idx);
					sh_d    = IW'(count_q);
					state_d = S_SHIFT;
				end
			end

			S_SHIFT: begin
				wr.en    = 1'b1;
				wr.addr  = sh_q;
				wr.entry = rd;
				if (CW'(sh_q) == at_q + CW'(1)) begin
					state_d = S_PUT;
				end else begin
					sh_d    = sh_q - IW'(1);
					rd_addr = sh_q - IW'(2);
				end
			end

			S_PUT: begin
				wr.en          = 1'b1;
				wr.addr        = IW'(at_q);
				wr.entry.key   = pos_q;
				wr.entry.color = color_q;
				count_d        = count_q + CW'(1);
				res_d.status   = acg_pkg::ST_STORED;
				state_d        = S_DONE;
			end

			S_LERP: begin
				if (lrsp.done) begin
					res_d.status    = acg_pkg::ST_COLOR;
					res_d.red_out   = lrsp.rgb[23:16];
					res_d.green_out = lrsp.rgb[15:8];
					res_d.blue_out  = lrsp.rgb[7:0];
					state_d         = S_DONE;
				end
			end

			S_DONE: begin
				// hold until the output register can take the beat
				if (out_free) begin
					state_d = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			sh_q        <= '0;
			at_q        <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			sh_q    <= sh_d;
			at_q    <= at_d;
			count_q <= count_d;
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			type_q  <= req.req_type;
			pos_q   <= req.position;
			color_q <= {req.red_in, req.green_in, req.blue_in};
		end
		prev_key_q   <= prev_key_d;
		prev_color_q <= prev_color_d;
		res_q        <= res_d;
		if (state_q == S_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The table never holds more anchors than it has room for.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(acg_pkg::MAX_ANCHORS))
		else $error("anchor count exceeds table size");

	// A result beat appears only after the sequencer reached its final state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result beat without a finished request");

	// The interpolator reports only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		lrsp.done |-> state_q == S_LERP)
		else $error("interpolator finished outside a query");

	// The anchor count changes only when a new anchor is placed.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(state_q) == S_PUT)
		else $error("anchor count changed outside an insert");

endmodule
